// ===== sv/rgbe_scanline_rle_decoder_macros.svh =====
// Assertion macros for the RGBE scanline decoder
`ifndef RGBE_SCANLINE_RLE_DECODER_MACROS_SVH
`define RGBE_SCANLINE_RLE_DECODER_MACROS_SVH

// Check a property on the rising clock edge, disabled while in reset
`define RGBE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property with the reset term spelled out by the caller
`define RGBE_ASSERT_RST(label, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`endif

// ===== sv/rgbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_pkg
// Shared types and constants for the RGBE scanline decoder.
// ----------------------------------------------------------------------------
package rgbe_pkg;

    localparam logic [1:0] ST_PIXEL     = 2'd0;
    localparam logic [1:0] ST_NO_PIXEL  = 2'd1;
    localparam logic [1:0] ST_BAD_WIDTH = 2'd2;
    localparam logic [1:0] ST_BAD_COUNT = 2'd3;

    localparam logic FN_BYTE = 1'b0;
    localparam logic FN_PULL = 1'b1;

    // configuration register indexes
    localparam logic IDX_WIDTH  = 1'b0;
    localparam logic IDX_HEIGHT = 1'b1;

    localparam logic [7:0] RLE_TAG  = 8'd2;
    localparam logic [7:0] RUN_BASE = 8'd128;

    // one accepted transaction as it sits in the queue
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } rgbe_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] word;
        logic        last_pixel;
    } rgbe_result_t;

endpackage

// ===== sv/rgbe_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_fifo
// Two-entry transaction queue between the input front and the decode back.
// ----------------------------------------------------------------------------
module rgbe_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rgbe_pkg::rgbe_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output rgbe_pkg::rgbe_item_t head_item
);
    import rgbe_pkg::*;

    rgbe_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `include "rgbe_scanline_rle_decoder_macros.svh"
    `RGBE_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
    `RGBE_ASSERT(a_no_underflow, pop |-> not_empty, "pop from empty queue")
    `RGBE_ASSERT(a_count_range, count_reg != 2'd3, "queue count out of range")

endmodule

// ===== sv/rgbe_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_engine
// Back end: marker check, RLE plane decode into the scanline store, pixel
// readout, raw pixel path and sticky errors.
// ----------------------------------------------------------------------------
module rgbe_engine #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [11:0]            image_width,
    input  logic [15:0]            image_height,
    input  logic                   height_wr,
    input  logic                   item_valid,
    input  rgbe_pkg::rgbe_item_t   item,
    output logic                   item_pop,
    output logic                   res_valid,
    input  logic                   res_stall,
    output rgbe_pkg::rgbe_result_t res
);
    import rgbe_pkg::*;

    localparam int PW    = $clog2(MAX_WIDTH + 1);
    localparam int AW    = $clog2(MAX_WIDTH);

    localparam logic [2:0] PH_MARKER  = 3'd0;
    localparam logic [2:0] PH_CODE    = 3'd1;
    localparam logic [2:0] PH_RUNVAL  = 3'd2;
    localparam logic [2:0] PH_LITERAL = 3'd3;
    localparam logic [2:0] PH_RAW     = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_ERR_W   = 3'd6;
    localparam logic [2:0] PH_ERR_C   = 3'd7;

    // sequencer: idle, run fill, readout read wait (4 planes)
    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_FILL = 2'd1;
    localparam logic [1:0] SQ_READ = 2'd2;

    logic [7:0] mem_0 [MAX_WIDTH];
    logic [7:0] mem_1 [MAX_WIDTH];
    logic [7:0] mem_2 [MAX_WIDTH];
    logic [7:0] mem_3 [MAX_WIDTH];
    logic [7:0] rd_0, rd_1, rd_2, rd_3;

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  sq_reg, sq_next;
    logic [31:0] marker_reg, marker_next;
    logic [1:0]  big_reg, big_next;
    logic [1:0]  plane_reg, plane_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]  pend_reg, pend_next;
    logic [15:0] rows_reg, rows_next;
    logic [PW-1:0] rdpos_reg, rdpos_next;
    logic        ready_reg, ready_next;
    logic [31:0] raw_reg, raw_next;
    logic [7:0]  fillv_reg, fillv_next;
    logic        rdlast_reg, rdlast_next;
    logic        ov_reg, ov_next;
    rgbe_result_t out_reg, out_next;

    logic [PW-1:0] w;
    logic [15:0]   eff_h;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [PW-1:0] remain;
    logic [7:0]    cnt;
    logic [15:0]   rows_m;
    logic [15:0]   mark_w;
    logic [31:0]   mark_new;
    logic [PW-1:0] pos_inc;
    logic          in_err;

    always_comb
    begin
        if (image_width == 12'd0)
        begin
            w = PW'(1);
        end
        else if (32'(image_width) > 32'(MAX_WIDTH))
        begin
            w = PW'(MAX_WIDTH);
        end
        else
        begin
            w = PW'(image_width);
        end
        eff_h = (image_height == 16'd0) ? 16'd1 : image_height;
    end

    assign remain   = (pos_reg < w) ? (w - pos_reg) : '0;
    assign cnt      = (item.data_byte > RUN_BASE) ? (item.data_byte - RUN_BASE)
                                                  : item.data_byte;
    assign rows_m   = (rows_reg == 16'd0) ? 16'd1 : rows_reg;
    assign mark_new = {marker_reg[23:0], item.data_byte};
    assign mark_w   = mark_new[15:0];
    assign pos_inc  = pos_reg + PW'(1);
    assign in_err   = (phase_reg == PH_ERR_W) || (phase_reg == PH_ERR_C);

    always_comb
    begin
        phase_next  = phase_reg;
        sq_next     = sq_reg;
        marker_next = marker_reg;
        big_next    = big_reg;
        plane_next  = plane_reg;
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        rows_next   = rows_reg;
        rdpos_next  = rdpos_reg;
        ready_next  = ready_reg;
        raw_next    = raw_reg;
        fillv_next  = fillv_reg;
        rdlast_next = rdlast_reg;
        ov_next     = ov_reg;
        out_next    = out_reg;
        item_pop    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = pos_reg[AW-1:0];
        wr_data     = item.data_byte;
        rd_en       = 1'b0;
        rd_addr     = rdpos_reg[AW-1:0];

        if (ov_reg && !res_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (sq_reg)
            SQ_FILL:
            begin
                // write one run entry per cycle
                wr_en     = 1'b1;
                wr_data   = fillv_reg;
                pos_next  = pos_inc;
                pend_next = pend_reg - 8'd1;
                if (pend_reg == 8'd1)
                begin
                    sq_next    = SQ_IDLE;
                    phase_next = PH_CODE;
                    if (pos_inc >= w)
                    begin
                        pos_next = '0;
                        if (plane_reg == 2'd3)
                        begin
                            plane_next = 2'd0;
                            ready_next = 1'b1;
                            rdpos_next = '0;
                            big_next   = 2'd0;
                            phase_next = PH_MARKER;
                        end
                        else
                        begin
                            plane_next = plane_reg + 2'd1;
                        end
                    end
                end
            end
            SQ_READ:
            begin
                if (!ov_reg || !res_stall)
                begin
                    sq_next  = SQ_IDLE;
                    ov_next  = 1'b1;
                    out_next = '{status: ST_PIXEL, word: {rd_0, rd_1, rd_2, rd_3},
                                 last_pixel: rdlast_reg};
                end
            end
            default:
            begin
                if (item_valid && (!ov_reg || !res_stall))
                begin
                    item_pop = 1'b1;
                    if (phase_reg == PH_ERR_W || phase_reg == PH_ERR_C)
                    begin
                        ov_next  = 1'b1;
                        out_next = '{status: (phase_reg == PH_ERR_W) ? ST_BAD_WIDTH
                                                                      : ST_BAD_COUNT,
                                     word: '0, last_pixel: 1'b0};
                    end
                    else if (item.func == FN_PULL)
                    begin
                        if (!ready_reg)
                        begin
                            ov_next  = 1'b1;
                            out_next = '{status: ST_NO_PIXEL, word: '0, last_pixel: 1'b0};
                        end
                        else
                        begin
                            rd_en       = 1'b1;
                            sq_next     = SQ_READ;
                            rdlast_next = 1'b0;
                            if (rdpos_reg + PW'(1) >= w)
                            begin
                                rdlast_next = (rows_reg <= 16'd1);
                                ready_next  = 1'b0;
                                rdpos_next  = '0;
                                rows_next   = (rows_reg != 16'd0) ? rows_reg - 16'd1 : 16'd0;
                                if (rows_reg <= 16'd1)
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                            else
                            begin
                                rdpos_next = rdpos_reg + PW'(1);
                            end
                        end
                    end
                    else if (!ready_reg && phase_reg != PH_DONE)
                    begin
                        unique case (phase_reg)
                            PH_MARKER:
                            begin
                                marker_next = mark_new;
                                big_next    = big_reg + 2'd1;
                                if (big_reg == 2'd3)
                                begin
                                    if (w < PW'(8) || mark_new[31:24] != RLE_TAG ||
                                        mark_new[23:16] != RLE_TAG || mark_new[15])
                                    begin
                                        raw_next   = 32'(w) * 32'(rows_m) - 32'd1;
                                        phase_next = (raw_next != 32'd0) ? PH_RAW : PH_DONE;
                                        ov_next    = 1'b1;
                                        out_next   = '{status: ST_PIXEL, word: mark_new,
                                                       last_pixel: (raw_next == 32'd0)};
                                    end
                                    else if (mark_w != 16'(w))
                                    begin
                                        phase_next = PH_ERR_W;
                                        ov_next    = 1'b1;
                                        out_next   = '{status: ST_BAD_WIDTH, word: '0,
                                                       last_pixel: 1'b0};
                                    end
                                    else
                                    begin
                                        plane_next = 2'd0;
                                        pos_next   = '0;
                                        phase_next = PH_CODE;
                                    end
                                end
                            end
                            PH_CODE:
                            begin
                                if (cnt == 8'd0 || PW'(cnt) > remain)
                                begin
                                    phase_next = PH_ERR_C;
                                    ov_next    = 1'b1;
                                    out_next   = '{status: ST_BAD_COUNT, word: '0,
                                                   last_pixel: 1'b0};
                                end
                                else
                                begin
                                    pend_next  = cnt;
                                    phase_next = (item.data_byte > RUN_BASE) ? PH_RUNVAL
                                                                             : PH_LITERAL;
                                end
                            end
                            PH_RUNVAL:
                            begin
                                fillv_next = item.data_byte;
                                sq_next    = SQ_FILL;
                            end
                            PH_LITERAL:
                            begin
                                wr_en     = 1'b1;
                                pos_next  = pos_inc;
                                pend_next = pend_reg - 8'd1;
                                if (pend_reg == 8'd1)
                                begin
                                    phase_next = PH_CODE;
                                    if (pos_inc >= w)
                                    begin
                                        pos_next = '0;
                                        if (plane_reg == 2'd3)
                                        begin
                                            plane_next = 2'd0;
                                            ready_next = 1'b1;
                                            rdpos_next = '0;
                                            big_next   = 2'd0;
                                            phase_next = PH_MARKER;
                                        end
                                        else
                                        begin
                                            plane_next = plane_reg + 2'd1;
                                        end
                                    end
                                end
                            end
                            PH_RAW:
                            begin
                                marker_next = mark_new;
                                big_next    = big_reg + 2'd1;
                                if (big_reg == 2'd3)
                                begin
                                    raw_next = (raw_reg != 32'd0) ? raw_reg - 32'd1 : 32'd0;
                                    if (raw_next == 32'd0)
                                    begin
                                        phase_next = PH_DONE;
                                    end
                                    ov_next  = 1'b1;
                                    out_next = '{status: ST_PIXEL, word: mark_new,
                                                 last_pixel: (raw_next == 32'd0)};
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
        endcase

        if (height_wr)
        begin
            rows_next = eff_h;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MARKER;
            sq_reg     <= SQ_IDLE;
            marker_reg <= '0;
            big_reg    <= '0;
            plane_reg  <= '0;
            pos_reg    <= '0;
            pend_reg   <= '0;
            rows_reg   <= 16'd1;
            rdpos_reg  <= '0;
            ready_reg  <= 1'b0;
            raw_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            sq_reg     <= sq_next;
            marker_reg <= marker_next;
            big_reg    <= big_next;
            plane_reg  <= plane_next;
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            rows_reg   <= rows_next;
            rdpos_reg  <= rdpos_next;
            ready_reg  <= ready_next;
            raw_reg    <= raw_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fillv_reg  <= fillv_next;
        rdlast_reg <= rdlast_next;
        out_reg    <= out_next;
    end

    // plane memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (plane_reg)
                2'd0: mem_0[wr_addr] <= wr_data;
                2'd1: mem_1[wr_addr] <= wr_data;
                2'd2: mem_2[wr_addr] <= wr_data;
                default: mem_3[wr_addr] <= wr_data;
            endcase
        end
        if (rd_en)
        begin
            rd_0 <= mem_0[rd_addr];
            rd_1 <= mem_1[rd_addr];
            rd_2 <= mem_2[rd_addr];
            rd_3 <= mem_3[rd_addr];
        end
    end

    assign res_valid = ov_reg;
    assign res       = out_reg;

    `include "rgbe_scanline_rle_decoder_macros.svh"
    `RGBE_ASSERT(a_hold_out, (ov_reg && res_stall) |=> ov_reg && $stable(out_reg), "lost result")
    `RGBE_ASSERT(a_fill_nopop, (sq_reg != SQ_IDLE) |-> !item_pop, "item taken while busy")
    `RGBE_ASSERT(a_pos_range, wr_en |-> 32'(pos_reg) < 32'(MAX_WIDTH), "write past plane")
    `RGBE_ASSERT(a_err_sticky, in_err |=> $stable(phase_reg), "error cleared")

endmodule

// ===== sv/rgbe_scanline_rle_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder
// Radiance RGBE pixel stream decoder with RLE scanline planes and readout.
// ----------------------------------------------------------------------------
// channel | direction | handshake         | payload
// in      | sink      | in_valid/in_stall | func, data_byte
// out     | source    | out_valid/out_stall | status, mantissas, exponent, last
// cfg     | sink      | cfg_we            | cfg_index, cfg_data
//
// A literal, code or marker byte is handled as it is popped from the queue; a
// run value byte holds the engine while its run (up to 127 entries) is written
// into the one-write plane memory; a pull waits for the registered plane read.
// Reset clears all control state; the plane memories are not cleared.
// The two-entry queue keeps accepting while the engine is busy or stalled, until it is full.
// ----------------------------------------------------------------------------
module rgbe_scanline_rle_decoder #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  red_mantissa,
    output logic [7:0]  green_mantissa,
    output logic [7:0]  blue_mantissa,
    output logic [7:0]  shared_exponent,
    output logic        last_pixel,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import rgbe_pkg::*;

    logic [11:0]  width_reg;
    logic [15:0]  height_reg;
    logic         q_full, q_ne, q_pop;
    rgbe_item_t   q_head, in_item;
    rgbe_result_t res;

    // take configuration writes at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd1;
            height_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == IDX_WIDTH)
            begin
                width_reg <= cfg_data[11:0];
            end
            else
            begin
                height_reg <= cfg_data;
            end
        end
    end

    assign in_item  = '{func: func, data_byte: data_byte};
    assign in_stall = q_full;

    rgbe_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_ne),
        .head_item (q_head)
    );

    rgbe_engine #(.MAX_WIDTH(MAX_WIDTH)) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (cfg_we && cfg_index == IDX_HEIGHT ? cfg_data : height_reg),
        .height_wr    (cfg_we && cfg_index == IDX_HEIGHT),
        .item_valid   (q_ne),
        .item         (q_head),
        .item_pop     (q_pop),
        .res_valid    (out_valid),
        .res_stall    (out_stall),
        .res          (res)
    );

    assign status          = res.status;
    assign red_mantissa    = res.word[31:24];
    assign green_mantissa  = res.word[23:16];
    assign blue_mantissa   = res.word[15:8];
    assign shared_exponent = res.word[7:0];
    assign last_pixel      = res.last_pixel;

endmodule
